FILE: hw/rtl/brac_pkg.sv
// ----------------------------------------------------------------------------
// brac_pkg
// Shared types and constants for the bitmap run allocator: map geometry,
// command opcodes, the classified command beat and the result beat.
// ----------------------------------------------------------------------------
package brac_pkg;

    // Map geometry
    localparam int MAP_BYTES = 512;
    localparam int MAP_BITS  = MAP_BYTES * 8;
    localparam int MAP_WORDS = (MAP_BYTES + 3) / 4;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = AW + 5;

    // Valid bits of the last map word; bits above the map read as used
    localparam int          LAST_BITS = MAP_BITS - 32 * (MAP_WORDS - 1);
    localparam logic [31:0] LAST_MASK = 32'((64'h1 << LAST_BITS) - 64'h1);

    // Widths of the item fields
    localparam int OP_W    = 3;
    localparam int IDX_W   = 12;
    localparam int LEN_W   = 13;
    localparam int START_W = 12;
    localparam int RUN_W   = LEN_W + 1;

    // Queue depths
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PW    = $clog2(RQ_DEPTH);

    // Command opcodes
    localparam logic [OP_W-1:0] OP_SCAN      = 3'd0;
    localparam logic [OP_W-1:0] OP_SET       = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

    // Command classes after decode
    typedef enum logic [2:0] {
        K_NOP,
        K_MISS,
        K_SCAN,
        K_SET,
        K_CLEAR,
        K_TEST,
        K_CLEAR_ALL
    } t_cmd_kind;

    // Execution engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [AW-1:0]    word;
        logic [4:0]       bit_ofs;
        logic [LEN_W-1:0] run_len;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_index;
        logic               bit_value;
    } t_result;

endpackage

FILE: hw/rtl/brac_front.sv
// ----------------------------------------------------------------------------
// brac_front
// Accepts command beats, classifies them against the map bounds and holds
// them in a short command queue for the execution engine.
// ----------------------------------------------------------------------------
module brac_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [brac_pkg::OP_W-1:0]    i_opcode,
    input  logic [brac_pkg::IDX_W-1:0]   i_bit_index,
    input  logic [brac_pkg::LEN_W-1:0]   i_run_length,
    output logic                         o_cmd_valid,
    output brac_pkg::t_cmd               o_cmd,
    input  logic                         i_cmd_pop
);

    brac_pkg::t_cmd                r_q [brac_pkg::CQ_DEPTH];
    logic [brac_pkg::CQ_PW-1:0]    r_wr_ptr;
    logic [brac_pkg::CQ_PW-1:0]    r_rd_ptr;
    logic [brac_pkg::CQ_PW:0]      r_count;
    brac_pkg::t_cmd                dec;
    logic                          idx_in_map;
    logic                          len_ok;
    logic                          wr_en;
    logic                          rd_en;

    // Classify the incoming beat
    assign idx_in_map = (32'(i_bit_index) < 32'(brac_pkg::MAP_BITS));
    assign len_ok     = (i_run_length != '0) &&
                        (32'(i_run_length) <= 32'(brac_pkg::MAP_BITS));

    always_comb begin
        dec.word    = brac_pkg::AW'(i_bit_index >> 5);
        dec.bit_ofs = i_bit_index[4:0];
        dec.run_len = i_run_length;
        unique case (i_opcode)
            brac_pkg::OP_SCAN:      dec.kind = len_ok ? brac_pkg::K_SCAN : brac_pkg::K_MISS;
            brac_pkg::OP_SET:       dec.kind = idx_in_map ? brac_pkg::K_SET : brac_pkg::K_NOP;
            brac_pkg::OP_CLEAR:     dec.kind = idx_in_map ? brac_pkg::K_CLEAR : brac_pkg::K_NOP;
            brac_pkg::OP_TEST:      dec.kind = idx_in_map ? brac_pkg::K_TEST : brac_pkg::K_NOP;
            brac_pkg::OP_CLEAR_ALL: dec.kind = brac_pkg::K_CLEAR_ALL;
            default:                dec.kind = brac_pkg::K_NOP;
        endcase
    end

    // Queue control
    assign full        = (r_count == (brac_pkg::CQ_PW+1)'(brac_pkg::CQ_DEPTH));
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (!wr_en && rd_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Hold the classified beat
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

FILE: hw/rtl/brac_back.sv
// ----------------------------------------------------------------------------
// brac_back
// Execution engine: owns the usage map memory, performs set and clear as
// read-modify-write and test as a read, and scans the map one word per cycle for a free run.
// ----------------------------------------------------------------------------
module brac_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  brac_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output brac_pkg::t_result o_res
);

    // Map storage and per-word valid bits
    logic [31:0]                 r_mem   [brac_pkg::MAP_WORDS];
    logic                        r_valid [brac_pkg::MAP_WORDS];
    logic [31:0]                 r_rd_data;
    logic                        r_rd_vld;

    brac_pkg::t_state            r_state;
    brac_pkg::t_state            n_state;
    brac_pkg::t_cmd              r_cmd;
    logic [brac_pkg::AW-1:0]     r_eval_word;
    logic [brac_pkg::RUN_W-1:0]  r_run;
    logic [brac_pkg::RUN_W-1:0]  n_run;
    logic [brac_pkg::POS_W-1:0]  r_run_start;
    logic [brac_pkg::POS_W-1:0]  n_run_start;

    logic                        start;
    logic                        rd_en;
    logic [brac_pkg::AW-1:0]     rd_addr;
    logic                        wr_en;
    logic [31:0]                 wr_data;
    logic                        clear_all;
    logic [31:0]                 cur;
    logic [31:0]                 bit_mask;

    // Scan datapath
    logic                        eval_last;
    logic [31:0]                 sw;
    logic [5:0]                  pl [6][32];
    logic [brac_pkg::RUN_W-1:0]  need;
    logic [5:0]                  need_c;
    logic [5:0]                  len_c;
    logic [31:0]                 hit;
    logic                        hit_any;
    logic [4:0]                  sel;
    logic [5:0]                  p_sel;
    logic [brac_pkg::POS_W-1:0]  word_base;
    logic [brac_pkg::POS_W-1:0]  hit_start;

    assign start    = (r_state == brac_pkg::ST_IDLE) && i_cmd_valid && !i_res_full;
    assign cur      = r_rd_vld ? r_rd_data : 32'h0;
    assign bit_mask = 32'h1 << r_cmd.bit_ofs;
    assign wr_data  = (r_cmd.kind == brac_pkg::K_SET) ? (cur | bit_mask) : (cur & ~bit_mask);

    // Mark bits above the map as used in the last word
    assign eval_last = (r_eval_word == brac_pkg::AW'(brac_pkg::MAP_WORDS - 1));
    assign sw        = cur | (eval_last ? ~brac_pkg::LAST_MASK : 32'h0);
    assign word_base = {r_eval_word, 5'd0};

    // Position (plus one) of the last used bit at or below each bit
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            pl[0][j] = sw[j] ? 6'(j + 1) : 6'd0;
        end
        for (int l = 0; l < 5; l++) begin
            for (int j = 0; j < 32; j++) begin
                if ((j >= (1 << l)) && (pl[l][j - (1 << l)] > pl[l][j])) begin
                    pl[l+1][j] = pl[l][j - (1 << l)];
                end else begin
                    pl[l+1][j] = pl[l][j];
                end
            end
        end
    end

    // Find the lowest bit at which a free run reaches the wanted length
    assign need   = brac_pkg::RUN_W'(r_cmd.run_len) - r_run;
    assign need_c = (need > brac_pkg::RUN_W'(32)) ? 6'd33 : need[5:0];
    assign len_c  = (r_cmd.run_len > brac_pkg::LEN_W'(32)) ? 6'd33 : r_cmd.run_len[5:0];

    always_comb begin
        for (int j = 0; j < 32; j++) begin
            if (pl[5][j] == 6'd0) begin
                hit[j] = (6'(j + 1) >= need_c);
            end else begin
                hit[j] = ((6'(j + 1) - pl[5][j]) >= len_c);
            end
        end
    end

    always_comb begin
        sel = 5'd0;
        for (int j = 31; j >= 0; j--) begin
            if (hit[j]) begin
                sel = 5'(j);
            end
        end
    end

    assign hit_any   = |hit;
    assign p_sel     = pl[5][sel];
    assign hit_start = (p_sel == 6'd0) ? r_run_start
                                       : word_base + brac_pkg::POS_W'(p_sel);

    // Carry the open run into the next word
    always_comb begin
        if (pl[5][31] == 6'd0) begin
            n_run       = r_run + brac_pkg::RUN_W'(32);
            n_run_start = r_run_start;
        end else begin
            n_run       = brac_pkg::RUN_W'(6'd32 - pl[5][31]);
            n_run_start = word_base + brac_pkg::POS_W'(pl[5][31]);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brac_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_cmd.kind)
                        brac_pkg::K_SET, brac_pkg::K_CLEAR, brac_pkg::K_TEST: begin
                            n_state = brac_pkg::ST_ACCESS;
                        end
                        brac_pkg::K_SCAN: n_state = brac_pkg::ST_SCAN;
                        default:          n_state = brac_pkg::ST_IDLE;
                    endcase
                end
            end
            brac_pkg::ST_ACCESS: n_state = brac_pkg::ST_IDLE;
            brac_pkg::ST_SCAN: begin
                if (hit_any || eval_last) begin
                    n_state = brac_pkg::ST_IDLE;
                end
            end
            default: n_state = brac_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd_pop         = 1'b0;
        o_res_push        = 1'b0;
        o_res.found       = 1'b1;
        o_res.start_index = '0;
        o_res.bit_value   = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        clear_all         = 1'b0;
        unique case (r_state)
            brac_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        brac_pkg::K_SET, brac_pkg::K_CLEAR, brac_pkg::K_TEST: begin
                            rd_en   = 1'b1;
                            rd_addr = i_cmd.word;
                        end
                        brac_pkg::K_SCAN: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                        end
                        default: begin
                            o_res_push  = 1'b1;
                            o_res.found = (i_cmd.kind != brac_pkg::K_MISS);
                            clear_all   = (i_cmd.kind == brac_pkg::K_CLEAR_ALL);
                        end
                    endcase
                end
            end
            brac_pkg::ST_ACCESS: begin
                o_res_push = 1'b1;
                if (r_cmd.kind == brac_pkg::K_TEST) begin
                    o_res.bit_value = cur[r_cmd.bit_ofs];
                end else begin
                    wr_en = 1'b1;
                end
            end
            brac_pkg::ST_SCAN: begin
                if (hit_any) begin
                    o_res_push        = 1'b1;
                    o_res.start_index = brac_pkg::START_W'(hit_start);
                end else if (eval_last) begin
                    o_res_push  = 1'b1;
                    o_res.found = 1'b0;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_eval_word + 1'b1;
                end
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    // State register and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= brac_pkg::ST_IDLE;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < brac_pkg::MAP_WORDS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (clear_all) begin
                for (int i = 0; i < brac_pkg::MAP_WORDS; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end else if (wr_en) begin
                r_valid[r_cmd.word] <= 1'b1;
            end
        end
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cmd.word] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Latch the command and advance the scan
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd       <= i_cmd;
            r_eval_word <= '0;
            r_run       <= '0;
            r_run_start <= '0;
        end else if (r_state == brac_pkg::ST_SCAN) begin
            r_eval_word <= r_eval_word + 1'b1;
            r_run       <= n_run;
            r_run_start <= n_run_start;
        end
    end

endmodule

FILE: hw/rtl/brac_result_q.sv
// ----------------------------------------------------------------------------
// brac_result_q
// Result queue: holds finished result beats until the receiver pops them.
// ----------------------------------------------------------------------------
module brac_result_q (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_res_push,
    input  brac_pkg::t_result                  i_res,
    output logic                               o_res_full,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_found,
    output logic [brac_pkg::START_W-1:0]       o_start_index,
    output logic                               o_bit_value
);

    brac_pkg::t_result             r_q [brac_pkg::RQ_DEPTH];
    logic [brac_pkg::RQ_PW-1:0]    r_wr_ptr;
    logic [brac_pkg::RQ_PW-1:0]    r_rd_ptr;
    logic [brac_pkg::RQ_PW:0]      r_count;
    logic                          wr_en;
    logic                          rd_en;
    brac_pkg::t_result             head;

    assign o_res_full    = (r_count == (brac_pkg::RQ_PW+1)'(brac_pkg::RQ_DEPTH));
    assign empty         = (r_count == '0);
    assign wr_en         = i_res_push && !o_res_full;
    assign rd_en         = pop && !empty;
    assign head          = r_q[r_rd_ptr];
    assign o_found       = head.found;
    assign o_start_index = head.start_index;
    assign o_bit_value   = head.bit_value;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (!wr_en && rd_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Hold result beats
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

endmodule

FILE: hw/rtl/bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// First-fit bitmap allocator over a 4096-bit usage map (128 words of 32).
//
// Command channel: push / full. A beat carries opcode, bit_index and
// run_length and is taken when push is high and full is low. Commands are
// scan for a free run, set bit, clear bit, test bit and clear all.
// Result channel: empty / pop. The oldest result (found, start_index,
// bit_value) is shown while empty is low and leaves when pop is high.
// Exactly one result beat is produced per command beat, in order.
//
// Clear all, unused opcodes and trivially failing scans are answered
// without a map access; set, clear and test read one map word, and set
// and clear write it back. A scan walks the map memory one word per cycle
// through its single read port and stops at the first fit or after the
// last word. The engine finishes each command before it takes the next.
// A two-beat command queue and a two-beat result queue decouple the sides:
// while the receiver stalls, commands keep queueing until both queues fill.
// Reset empties both queues and marks every map bit free at once.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [brac_pkg::OP_W-1:0]         i_opcode,
    input  logic [brac_pkg::IDX_W-1:0]        i_bit_index,
    input  logic [brac_pkg::LEN_W-1:0]        i_run_length,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_found,
    output logic [brac_pkg::START_W-1:0]      o_start_index,
    output logic                              o_bit_value
);

    logic              cmd_valid;
    brac_pkg::t_cmd    cmd;
    logic              cmd_pop;
    logic              res_full;
    logic              res_push;
    brac_pkg::t_result res;

    // Front: accept and classify
    brac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_bit_index  (i_bit_index),
        .i_run_length (i_run_length),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // Back: execute against the map
    brac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Result queue toward the receiver
    brac_result_q u_result_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_push    (res_push),
        .i_res         (res),
        .o_res_full    (res_full),
        .empty         (empty),
        .pop           (pop),
        .o_found       (o_found),
        .o_start_index (o_start_index),
        .o_bit_value   (o_bit_value)
    );

    // Engine never drops a result into a full queue
    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !(res_push && res_full)
    ) else $error("result pushed into full result queue");

    // Engine only takes commands that are present
    a_pop_needs_cmd: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cmd_pop |-> cmd_valid
    ) else $error("command popped from empty command queue");

    // Reset leaves both queues empty
    a_reset_empty: assert property (
        @(posedge i_clk) !i_rst_n |=> (!full && empty && !cmd_valid)
    ) else $error("queues not empty after reset");

endmodule

FILE: tb/tb_bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_run_allocator_core
// Self-checking bench for the first-fit bitmap allocator. A driver feeds
// command beats from a pending list, and a monitor predicts each result at
// accept time from its own copy of the usage map. Results are checked in
// order, field by field. Traffic is mostly allocate/free sequences over a
// fragmented map, plus scattered bit traffic, odd lengths and spare opcodes,
// run under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_bitmap_run_allocator_core;

    localparam int MAP_BITS   = brac_pkg::MAP_BITS;
    localparam int PHASE_CMDS = 400;
    localparam int DRAIN_CYC  = 140;

    typedef struct {
        logic [brac_pkg::OP_W-1:0]  opcode;
        logic [brac_pkg::IDX_W-1:0] bit_index;
        logic [brac_pkg::LEN_W-1:0] run_length;
    } t_cmd_beat;

    // Block ports
    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         push         = 1'b0;
    logic                         full;
    logic [brac_pkg::OP_W-1:0]    i_opcode     = '0;
    logic [brac_pkg::IDX_W-1:0]   i_bit_index  = '0;
    logic [brac_pkg::LEN_W-1:0]   i_run_length = '0;
    logic                         empty;
    logic                         pop          = 1'b0;
    logic                         o_found;
    logic [brac_pkg::START_W-1:0] o_start_index;
    logic                         o_bit_value;

    // Stimulus side
    t_cmd_beat   pending_cmds[$];
    logic [MAP_BITS-1:0] plan_bits = '0;
    int          alloc_start[$];
    int          alloc_len[$];
    int          cmds_queued    = 0;
    int          cmds_sent      = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // Prediction and checking side
    logic [MAP_BITS-1:0]  usage_bits = '0;
    brac_pkg::t_result    expected_results[$];
    int          cmds_accepted = 0;
    int          fail_count    = 0;
    int          n_scan = 0, n_scan_hit = 0, n_set = 0, n_clear = 0;
    int          n_test = 0, n_test_one = 0, n_clear_all = 0, n_spare = 0;
    int          n_results = 0;

    bitmap_run_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_bit_index   (i_bit_index),
        .i_run_length  (i_run_length),
        .empty         (empty),
        .pop           (pop),
        .o_found       (o_found),
        .o_start_index (o_start_index),
        .o_bit_value   (o_bit_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Lowest start of the first run of len free bits, -1 when none fits
    function automatic int first_fit(input logic [MAP_BITS-1:0] m, input int len);
        int run;
        run = 0;
        if (len == 0 || len > MAP_BITS) return -1;
        for (int n = 0; n < MAP_BITS; n++) begin
            run = m[n] ? 0 : run + 1;
            if (run == len) return n + 1 - len;
        end
        return -1;
    endfunction

    // Apply one command to the predicted map and return its result beat
    function automatic brac_pkg::t_result serve_command(
        input logic [brac_pkg::OP_W-1:0]  op,
        input logic [brac_pkg::IDX_W-1:0] idx,
        input logic [brac_pkg::LEN_W-1:0] len
    );
        brac_pkg::t_result r;
        int                s;
        r.found       = 1'b1;
        r.start_index = '0;
        r.bit_value   = 1'b0;
        case (op)
            brac_pkg::OP_SCAN: begin
                s = first_fit(usage_bits, int'(len));
                if (s < 0) r.found = 1'b0;
                else r.start_index = brac_pkg::START_W'(s);
            end
            brac_pkg::OP_SET: begin
                if (int'(idx) < MAP_BITS) usage_bits[idx] = 1'b1;
            end
            brac_pkg::OP_CLEAR: begin
                if (int'(idx) < MAP_BITS) usage_bits[idx] = 1'b0;
            end
            brac_pkg::OP_TEST: begin
                if (int'(idx) < MAP_BITS) r.bit_value = usage_bits[idx];
            end
            brac_pkg::OP_CLEAR_ALL: usage_bits = '0;
            default: ;
        endcase
        return r;
    endfunction

    // Append a command and track its effect on the planning map
    task automatic queue_command(input logic [brac_pkg::OP_W-1:0] op, input int idx,
                                 input int len);
        t_cmd_beat b;
        b.opcode     = op;
        b.bit_index  = brac_pkg::IDX_W'(idx);
        b.run_length = brac_pkg::LEN_W'(len);
        pending_cmds.push_back(b);
        cmds_queued++;
        case (op)
            brac_pkg::OP_SET:   plan_bits[b.bit_index] = 1'b1;
            brac_pkg::OP_CLEAR: plan_bits[b.bit_index] = 1'b0;
            brac_pkg::OP_CLEAR_ALL: begin
                plan_bits = '0;
                alloc_start.delete();
                alloc_len.delete();
            end
            default: ;
        endcase
    endtask

    // Hold until every queued command is in and every result is out
    task automatic wait_drained();
        while (cmds_accepted != cmds_queued || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Corner cases: length extremes, map edges, word boundary, spare opcodes
    task automatic queue_directed();
        queue_command(brac_pkg::OP_TEST, 0, 8191);
        queue_command(brac_pkg::OP_SCAN, 4095, 0);
        queue_command(brac_pkg::OP_SCAN, 0, 1);
        queue_command(brac_pkg::OP_SCAN, 0, MAP_BITS);
        queue_command(brac_pkg::OP_SCAN, 0, MAP_BITS + 1);
        queue_command(brac_pkg::OP_SCAN, 0, 8191);
        queue_command(brac_pkg::OP_SET, 0, 0);
        queue_command(brac_pkg::OP_SET, 4095, 8191);
        queue_command(brac_pkg::OP_TEST, 0, 0);
        queue_command(brac_pkg::OP_TEST, 4095, 0);
        queue_command(brac_pkg::OP_SCAN, 0, 1);
        queue_command(brac_pkg::OP_SCAN, 0, MAP_BITS - 2);
        queue_command(brac_pkg::OP_SCAN, 0, MAP_BITS - 1);
        queue_command(brac_pkg::OP_SET, 31, 0);
        queue_command(brac_pkg::OP_SET, 32, 0);
        queue_command(brac_pkg::OP_SCAN, 0, 30);
        queue_command(brac_pkg::OP_SCAN, 0, 31);
        queue_command(brac_pkg::OP_CLEAR, 0, 4096);
        queue_command(brac_pkg::OP_TEST, 0, 0);
        queue_command(brac_pkg::OP_CLEAR_ALL + 3'd1, 4095, 8191);
        queue_command(brac_pkg::OP_CLEAR_ALL + 3'd2, 1234, 77);
        queue_command(brac_pkg::OP_CLEAR_ALL + 3'd3, 0, 0);
        queue_command(brac_pkg::OP_CLEAR_ALL, 4095, 8191);
        queue_command(brac_pkg::OP_TEST, 4095, 0);
        queue_command(brac_pkg::OP_SCAN, 0, MAP_BITS);
    endtask

    // Mostly allocate/free sequences, with scattered bits and noise mixed in
    task automatic queue_random(input int count);
        int target, pick, len, s, j;
        target = cmds_queued + count;
        while (cmds_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // allocate: scan, then claim the run or pin one bit inside it
                j = $urandom_range(0, 99);
                len = (j < 70) ? $urandom_range(1, 16)
                    : (j < 90) ? $urandom_range(17, 200) : $urandom_range(201, 1500);
                queue_command(brac_pkg::OP_SCAN, $urandom_range(0, 4095), len);
                s = first_fit(plan_bits, len);
                if (s >= 0 && len <= 16) begin
                    for (int k = 0; k < len; k++)
                        queue_command(brac_pkg::OP_SET, s + k, $urandom_range(0, 8191));
                    alloc_start.push_back(s);
                    alloc_len.push_back(len);
                end else if (s >= 0) begin
                    queue_command(brac_pkg::OP_SET, s + $urandom_range(0, len - 1),
                                  $urandom_range(0, 8191));
                end
            end else if (pick < 50) begin
                // free a claimed run, probing it first now and then
                if (alloc_start.size() != 0) begin
                    j = $urandom_range(0, alloc_start.size() - 1);
                    s = alloc_start[j];
                    len = alloc_len[j];
                    alloc_start.delete(j);
                    alloc_len.delete(j);
                    if ($urandom_range(0, 1))
                        queue_command(brac_pkg::OP_TEST, s + $urandom_range(0, len - 1),
                                      $urandom_range(0, 8191));
                    for (int k = 0; k < len; k++)
                        queue_command(brac_pkg::OP_CLEAR, s + k, $urandom_range(0, 8191));
                end else begin
                    queue_command(brac_pkg::OP_SET, $urandom_range(0, 4095),
                                  $urandom_range(0, 8191));
                end
            end else if (pick < 65) begin
                if (alloc_start.size() != 0 && $urandom_range(0, 1)) begin
                    j = $urandom_range(0, alloc_start.size() - 1);
                    s = alloc_start[j] + $urandom_range(0, alloc_len[j] - 1);
                end else begin
                    s = $urandom_range(0, 4095);
                end
                queue_command(brac_pkg::OP_TEST, s, $urandom_range(0, 8191));
            end else if (pick < 80) begin
                queue_command(brac_pkg::OP_SET, $urandom_range(0, 4095),
                              $urandom_range(0, 8191));
            end else if (pick < 88) begin
                queue_command(brac_pkg::OP_CLEAR, $urandom_range(0, 4095),
                              $urandom_range(0, 8191));
            end else if (pick < 96) begin
                queue_command(brac_pkg::OP_SCAN, $urandom_range(0, 4095),
                              $urandom_range(1, MAP_BITS));
            end else if (pick < 99) begin
                // noise: zero or oversize lengths, spare opcodes
                j = $urandom_range(0, 2);
                if (j == 0)
                    queue_command(brac_pkg::OP_SCAN, $urandom_range(0, 4095), 0);
                else if (j == 1)
                    queue_command(brac_pkg::OP_SCAN, $urandom_range(0, 4095),
                                  $urandom_range(MAP_BITS + 1, 8191));
                else
                    queue_command(brac_pkg::OP_CLEAR_ALL + 3'($urandom_range(1, 3)),
                                  $urandom_range(0, 4095), $urandom_range(0, 8191));
            end else begin
                queue_command(brac_pkg::OP_CLEAR_ALL, $urandom_range(0, 4095),
                              $urandom_range(0, 8191));
            end
        end
    endtask

    // Driver: present command beats, hold each until taken, randomize pop
    always @(negedge i_clk) begin
        t_cmd_beat nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || cmds_accepted == cmds_sent) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                cmds_sent++;
                push         <= 1'b1;
                i_opcode     <= nxt.opcode;
                i_bit_index  <= nxt.bit_index;
                i_run_length <= nxt.run_length;
            end else begin
                push         <= 1'b0;
                i_opcode     <= brac_pkg::OP_W'($urandom);
                i_bit_index  <= brac_pkg::IDX_W'($urandom);
                i_run_length <= brac_pkg::LEN_W'($urandom);
            end
        end
        pop <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predict on each accepted command, check each accepted result
    always @(posedge i_clk) begin
        brac_pkg::t_result r;
        if (i_rst_n) begin
            if (push && !full) begin
                r = serve_command(i_opcode, i_bit_index, i_run_length);
                expected_results.push_back(r);
                cmds_accepted++;
                case (i_opcode)
                    brac_pkg::OP_SCAN: begin
                        n_scan++;
                        if (r.found) n_scan_hit++;
                    end
                    brac_pkg::OP_SET:   n_set++;
                    brac_pkg::OP_CLEAR: n_clear++;
                    brac_pkg::OP_TEST: begin
                        n_test++;
                        if (r.bit_value) n_test_one++;
                    end
                    brac_pkg::OP_CLEAR_ALL: n_clear_all++;
                    default: n_spare++;
                endcase
            end
            if (pop && !empty) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end else begin
                    r = expected_results.pop_front();
                    if (o_found !== r.found) begin
                        $error("found: expected %0d, got %0d", r.found, o_found);
                        fail_count++;
                    end
                    if (o_start_index !== r.start_index) begin
                        $error("start_index: expected %0d, got %0d",
                               r.start_index, o_start_index);
                        fail_count++;
                    end
                    if (o_bit_value !== r.bit_value) begin
                        $error("bit_value: expected %0d, got %0d", r.bit_value, o_bit_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Sequence: reset, corner cases, then four idling mixes
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        queue_random(PHASE_CMDS);
        wait_drained();

        send_idle_pct = 77;
        queue_random(PHASE_CMDS);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 77;
        queue_random(PHASE_CMDS);
        wait_drained();

        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random(PHASE_CMDS);
        wait_drained();

        // let any stray late beat show up before the verdict
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYC) @(negedge i_clk);

        $display("Covered %0d commands, %0d results: %0d scans (%0d hit), %0d sets, %0d clears",
                 cmds_accepted, n_results, n_scan, n_scan_hit, n_set, n_clear);
        $display("  %0d tests (%0d read used), %0d clear-alls, %0d spare opcodes",
                 n_test, n_test_one, n_clear_all, n_spare);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4_800_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/brac_pkg.sv
hw/rtl/brac_front.sv
hw/rtl/brac_back.sv
hw/rtl/brac_result_q.sv
hw/rtl/bitmap_run_allocator_core.sv
tb/tb_bitmap_run_allocator_core.sv
